// ===== sv/orl_pkg.sv =====
// Shared types, codes and sizes for the ordered record list.
`timescale 1ns / 1ps
package orl_pkg;

	localparam int DEPTH       = 64;
	localparam int CODE_BITS   = 16;
	localparam int CODE_PORT_W = 16;
	localparam int POS_W       = 7;
	localparam int IDX_W       = $clog2(DEPTH);
	localparam int CNT_W       = $clog2(DEPTH + 1);
	localparam int CMP_W       = (CNT_W > POS_W) ? CNT_W : POS_W;

	localparam logic [2:0] OP_INS_HEAD = 3'd0;
	localparam logic [2:0] OP_INS_TAIL = 3'd1;
	localparam logic [2:0] OP_INS_AT   = 3'd2;
	localparam logic [2:0] OP_DEL_HEAD = 3'd3;
	localparam logic [2:0] OP_DEL_TAIL = 3'd4;
	localparam logic [2:0] OP_DEL_AT   = 3'd5;
	localparam logic [2:0] OP_FIND     = 3'd6;

	localparam logic [2:0] STAT_OK       = 3'd0;
	localparam logic [2:0] STAT_EMPTY    = 3'd1;
	localparam logic [2:0] STAT_BADPOS   = 3'd2;
	localparam logic [2:0] STAT_FULL     = 3'd3;
	localparam logic [2:0] STAT_NOTFOUND = 3'd4;

	typedef struct packed {
		logic [CODE_BITS-1:0] country;
		logic [CODE_BITS-1:0] city;
		logic [CODE_BITS-1:0] rest;
	} rec_t;

	typedef enum logic [1:0] {
		SH_HOLD,
		SH_INS,
		SH_DEL,
		SH_ROT
	} shift_op_t;

	typedef struct packed {
		shift_op_t        op;
		logic [IDX_W-1:0] idx;
	} cell_cmd_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SEARCH,
		ST_REPORT
	} state_t;

	typedef struct packed {
		logic             searching;
		logic [CNT_W-1:0] count;
	} ctrl_mon_t;

endpackage

// ===== sv/ordered_record_list.sv =====
// Top level of the ordered record list: sequencer plus a ring of record cells.
//
//   channel | direction | transfer on           | payload
//   req     | in        | req_valid & req_ready | opcode, position, three codes
//   rsp     | out       | rsp_valid & rsp_ready | status, found fields, entry_count
//
// Inserts and deletes shift the cells from the target slot on to or from their neighbour at once.
// A find rotates the whole ring of DEPTH cells past the head comparator, then loads
// the result into the held reply.
// Reset clears the record count and the control state; the cells need no reset.
// An update waits while a result is held; a find is taken and stalls only to report.
`timescale 1ns / 1ps
module ordered_record_list (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             req_valid,
	output logic                             req_ready,
	input  logic [2:0]                       opcode,
	input  logic [orl_pkg::POS_W-1:0]        position,
	input  logic [orl_pkg::CODE_PORT_W-1:0]  country_code,
	input  logic [orl_pkg::CODE_PORT_W-1:0]  city_code,
	input  logic [orl_pkg::CODE_PORT_W-1:0]  restaurant_code,
	output logic                             rsp_valid,
	input  logic                             rsp_ready,
	output logic [2:0]                       status,
	output logic [orl_pkg::POS_W-1:0]        found_position,
	output logic [orl_pkg::CODE_PORT_W-1:0]  found_country,
	output logic [orl_pkg::CODE_PORT_W-1:0]  found_city,
	output logic [orl_pkg::POS_W-1:0]        entry_count
);

	orl_pkg::cell_cmd_t cmd;
	orl_pkg::rec_t      new_rec;
	orl_pkg::ctrl_mon_t mon;
	orl_pkg::rec_t      cells [orl_pkg::DEPTH];

	orl_ctrl u_ctrl (
		.clk             (clk),
		.arst_n          (arst_n),
		.req_valid       (req_valid),
		.req_ready       (req_ready),
		.opcode          (opcode),
		.position        (position),
		.country_code    (country_code),
		.city_code       (city_code),
		.restaurant_code (restaurant_code),
		.head            (cells[0]),
		.cmd             (cmd),
		.new_rec         (new_rec),
		.rsp_valid       (rsp_valid),
		.rsp_ready       (rsp_ready),
		.status          (status),
		.found_position  (found_position),
		.found_country   (found_country),
		.found_city      (found_city),
		.entry_count     (entry_count),
		.mon             (mon)
	);

	// Close the chain into a ring so a full rotation restores the order.
	for (genvar i = 0; i < orl_pkg::DEPTH; i++) begin : g_cell
		orl_cell u_cell (
			.clk     (clk),
			.cmd     (cmd),
			.my_idx  (orl_pkg::IDX_W'(i)),
			.left    (cells[(i + orl_pkg::DEPTH - 1) % orl_pkg::DEPTH]),
			.right   (cells[(i + 1) % orl_pkg::DEPTH]),
			.new_rec (new_rec),
			.rec     (cells[i])
		);
	end

`ifndef SYNTHESIS
	a_busy_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		mon.searching |-> !req_ready)
		else $error("request taken during a find");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		mon.count <= orl_pkg::CNT_W'(orl_pkg::DEPTH))
		else $error("record count above depth");

	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && status == orl_pkg::STAT_FULL)
		|-> mon.count == orl_pkg::CNT_W'(orl_pkg::DEPTH))
		else $error("full reported on a list with room");

	a_found_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && found_position != '0) |-> status == orl_pkg::STAT_OK)
		else $error("match position without ok status");
`endif

endmodule

// ===== sv/orl_cell.sv =====
// One record cell of the chain: holds a record, takes from a neighbour or the new record on shifts.
`timescale 1ns / 1ps
module orl_cell (
	input  logic                       clk,
	input  orl_pkg::cell_cmd_t         cmd,
	input  logic [orl_pkg::IDX_W-1:0]  my_idx,
	input  orl_pkg::rec_t              left,
	input  orl_pkg::rec_t              right,
	input  orl_pkg::rec_t              new_rec,
	output orl_pkg::rec_t              rec
);

	orl_pkg::rec_t rec_q;

	always_ff @(posedge clk) begin
		unique case (cmd.op)
			orl_pkg::SH_HOLD: rec_q <= rec_q;
			orl_pkg::SH_INS: begin
				if (my_idx > cmd.idx) begin
					rec_q <= left;
				end else if (my_idx == cmd.idx) begin
					rec_q <= new_rec;
				end
			end
			orl_pkg::SH_DEL: begin
				if (my_idx >= cmd.idx) begin
					rec_q <= right;
				end
			end
			orl_pkg::SH_ROT: rec_q <= right;
			default: rec_q <= rec_q;
		endcase
	end

	assign rec = rec_q;

endmodule

// ===== sv/orl_ctrl.sv =====
// Sequencer: decodes operations, drives the cell chain, walks finds, holds the result.
`timescale 1ns / 1ps
module orl_ctrl (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             req_valid,
	output logic                             req_ready,
	input  logic [2:0]                       opcode,
	input  logic [orl_pkg::POS_W-1:0]        position,
	input  logic [orl_pkg::CODE_PORT_W-1:0]  country_code,
	input  logic [orl_pkg::CODE_PORT_W-1:0]  city_code,
	input  logic [orl_pkg::CODE_PORT_W-1:0]  restaurant_code,
	input  orl_pkg::rec_t                    head,
	output orl_pkg::cell_cmd_t               cmd,
	output orl_pkg::rec_t                    new_rec,
	output logic                             rsp_valid,
	input  logic                             rsp_ready,
	output logic [2:0]                       status,
	output logic [orl_pkg::POS_W-1:0]        found_position,
	output logic [orl_pkg::CODE_PORT_W-1:0]  found_country,
	output logic [orl_pkg::CODE_PORT_W-1:0]  found_city,
	output logic [orl_pkg::POS_W-1:0]        entry_count,
	output orl_pkg::ctrl_mon_t               mon
);

	orl_pkg::state_t state_q, state_d;

	logic [orl_pkg::CNT_W-1:0]     count_q;
	logic [orl_pkg::IDX_W-1:0]     step_q;
	logic [orl_pkg::CODE_BITS-1:0] key_q;
	logic                          hit_q;
	logic [orl_pkg::IDX_W-1:0]     hit_pos_q;
	logic [orl_pkg::CODE_BITS-1:0] hit_country_q;
	logic [orl_pkg::CODE_BITS-1:0] hit_city_q;

	logic                          rsp_valid_q;
	logic [2:0]                    status_q;
	logic [orl_pkg::CNT_W-1:0]     fpos_q;
	logic [orl_pkg::CODE_BITS-1:0] fcountry_q;
	logic [orl_pkg::CODE_BITS-1:0] fcity_q;
	logic [orl_pkg::CNT_W-1:0]     rcount_q;

	logic                          accept;
	logic                          out_free;
	logic                          is_find;
	logic                          last_step;
	logic                          head_match;
	logic [orl_pkg::CMP_W-1:0]     pos_x;
	logic [orl_pkg::CMP_W-1:0]     cnt_x;
	logic [2:0]                    dec_status;
	orl_pkg::shift_op_t            dec_shift;
	logic [orl_pkg::CMP_W-1:0]     dec_idx;
	logic [orl_pkg::CNT_W-1:0]     dec_count;
	logic [orl_pkg::CNT_W-1:0]     hit_num;

	assign out_free  = !rsp_valid_q || rsp_ready;
	assign is_find   = (opcode == orl_pkg::OP_FIND);
	assign req_ready = (state_q == orl_pkg::ST_IDLE) && (out_free || is_find);
	assign accept    = req_valid && req_ready;
	assign last_step = (step_q == orl_pkg::IDX_W'(orl_pkg::DEPTH - 1));
	assign head_match = !hit_q && (orl_pkg::CNT_W'(step_q) < count_q)
		&& (head.rest == key_q);
	assign hit_num   = orl_pkg::CNT_W'(hit_pos_q) + orl_pkg::CNT_W'(1);

	assign pos_x = orl_pkg::CMP_W'(position);
	assign cnt_x = orl_pkg::CMP_W'(count_q);

	// Work out the target slot and the outcome of an insert or delete.
	always_comb begin
		dec_status = orl_pkg::STAT_OK;
		dec_shift  = orl_pkg::SH_HOLD;
		dec_idx    = '0;
		dec_count  = count_q;
		unique case (opcode)
			orl_pkg::OP_INS_HEAD, orl_pkg::OP_INS_TAIL, orl_pkg::OP_INS_AT: begin
				if (count_q == orl_pkg::CNT_W'(orl_pkg::DEPTH)) begin
					dec_status = orl_pkg::STAT_FULL;
				end else begin
					dec_shift = orl_pkg::SH_INS;
					dec_count = count_q + orl_pkg::CNT_W'(1);
					priority if (count_q == '0 || opcode == orl_pkg::OP_INS_HEAD
						|| (opcode == orl_pkg::OP_INS_AT
						&& pos_x <= orl_pkg::CMP_W'(1))) begin
						dec_idx = '0;
					end else if (opcode == orl_pkg::OP_INS_TAIL || pos_x >= cnt_x) begin
						dec_idx = cnt_x;
					end else begin
						dec_idx = pos_x - orl_pkg::CMP_W'(1);
					end
				end
			end
			orl_pkg::OP_DEL_HEAD, orl_pkg::OP_DEL_TAIL, orl_pkg::OP_DEL_AT: begin
				priority if (count_q == '0) begin
					dec_status = orl_pkg::STAT_EMPTY;
				end else if (opcode == orl_pkg::OP_DEL_HEAD
					|| (opcode == orl_pkg::OP_DEL_AT && pos_x == orl_pkg::CMP_W'(1))) begin
					dec_shift = orl_pkg::SH_DEL;
					dec_count = count_q - orl_pkg::CNT_W'(1);
				end else if (opcode == orl_pkg::OP_DEL_TAIL) begin
					dec_shift = orl_pkg::SH_DEL;
					dec_idx   = cnt_x - orl_pkg::CMP_W'(1);
					dec_count = count_q - orl_pkg::CNT_W'(1);
				end else if (pos_x == '0 || pos_x > cnt_x) begin
					dec_status = orl_pkg::STAT_BADPOS;
				end else begin
					dec_shift = orl_pkg::SH_DEL;
					dec_idx   = pos_x - orl_pkg::CMP_W'(1);
					dec_count = count_q - orl_pkg::CNT_W'(1);
				end
			end
			default: begin
			end
		endcase
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			orl_pkg::ST_IDLE: begin
				if (accept && is_find) begin
					state_d = orl_pkg::ST_SEARCH;
				end
			end
			orl_pkg::ST_SEARCH: begin
				if (last_step) begin
					state_d = orl_pkg::ST_REPORT;
				end
			end
			orl_pkg::ST_REPORT: begin
				if (out_free) begin
					state_d = orl_pkg::ST_IDLE;
				end
			end
			default: state_d = orl_pkg::ST_IDLE;
		endcase
	end

	// Chain command: one shift on an accepted update, a full rotation during a find.
	always_comb begin
		cmd.op  = orl_pkg::SH_HOLD;
		cmd.idx = orl_pkg::IDX_W'(dec_idx);
		unique case (state_q)
			orl_pkg::ST_IDLE: begin
				if (accept && !is_find) begin
					cmd.op = dec_shift;
				end
			end
			orl_pkg::ST_SEARCH: cmd.op = orl_pkg::SH_ROT;
			orl_pkg::ST_REPORT: cmd.op = orl_pkg::SH_HOLD;
			default: cmd.op = orl_pkg::SH_HOLD;
		endcase
	end

	assign new_rec.country = orl_pkg::CODE_BITS'(country_code);
	assign new_rec.city    = orl_pkg::CODE_BITS'(city_code);
	assign new_rec.rest    = orl_pkg::CODE_BITS'(restaurant_code);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= orl_pkg::ST_IDLE;
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
			hit_q       <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == orl_pkg::ST_IDLE && accept && !is_find) begin
				count_q     <= dec_count;
				rsp_valid_q <= 1'b1;
			end else if (state_q == orl_pkg::ST_REPORT && out_free) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			if (state_q == orl_pkg::ST_IDLE && accept) begin
				hit_q <= 1'b0;
			end else if (state_q == orl_pkg::ST_SEARCH && head_match) begin
				hit_q <= 1'b1;
			end
		end
	end

	// Payload registers: search context and the held result.
	always_ff @(posedge clk) begin
		if (state_q == orl_pkg::ST_IDLE && accept) begin
			key_q  <= new_rec.rest;
			step_q <= '0;
		end else if (state_q == orl_pkg::ST_SEARCH) begin
			step_q <= step_q + orl_pkg::IDX_W'(1);
		end
		if (state_q == orl_pkg::ST_SEARCH && head_match) begin
			hit_pos_q     <= step_q;
			hit_country_q <= head.country;
			hit_city_q    <= head.city;
		end
		if (state_q == orl_pkg::ST_IDLE && accept && !is_find) begin
			status_q   <= dec_status;
			fpos_q     <= '0;
			fcountry_q <= '0;
			fcity_q    <= '0;
			rcount_q   <= dec_count;
		end else if (state_q == orl_pkg::ST_REPORT && out_free) begin
			status_q   <= hit_q ? orl_pkg::STAT_OK : orl_pkg::STAT_NOTFOUND;
			fpos_q     <= hit_q ? hit_num : '0;
			fcountry_q <= hit_q ? hit_country_q : '0;
			fcity_q    <= hit_q ? hit_city_q : '0;
			rcount_q   <= count_q;
		end
	end

	assign rsp_valid      = rsp_valid_q;
	assign status         = status_q;
	assign found_position = orl_pkg::POS_W'(fpos_q);
	assign found_country  = orl_pkg::CODE_PORT_W'(fcountry_q);
	assign found_city     = orl_pkg::CODE_PORT_W'(fcity_q);
	assign entry_count    = orl_pkg::POS_W'(rcount_q);

	assign mon.searching = (state_q != orl_pkg::ST_IDLE);
	assign mon.count     = count_q;

endmodule

// ===== tb/orl_checker.sv =====
// Checker for the ordered record list: tracks the list contents and compares every result.
`timescale 1ns / 1ps
module orl_checker (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             req_valid,
	input  logic                             req_ready,
	input  logic [2:0]                       opcode,
	input  logic [orl_pkg::POS_W-1:0]        position,
	input  logic [orl_pkg::CODE_PORT_W-1:0]  country_code,
	input  logic [orl_pkg::CODE_PORT_W-1:0]  city_code,
	input  logic [orl_pkg::CODE_PORT_W-1:0]  restaurant_code,
	input  logic                             rsp_valid,
	input  logic                             rsp_ready,
	input  logic [2:0]                       status,
	input  logic [orl_pkg::POS_W-1:0]        found_position,
	input  logic [orl_pkg::CODE_PORT_W-1:0]  found_country,
	input  logic [orl_pkg::CODE_PORT_W-1:0]  found_city,
	input  logic [orl_pkg::POS_W-1:0]        entry_count,
	output int                               mismatches,
	output int                               outstanding
);
	import orl_pkg::*;

	typedef struct packed {
		logic [2:0]             status;
		logic [POS_W-1:0]       fpos;
		logic [CODE_PORT_W-1:0] fcountry;
		logic [CODE_PORT_W-1:0] fcity;
		logic [POS_W-1:0]       count;
	} reply_t;

	rec_t   roster[$];
	reply_t pending_replies[$];
	reply_t want;
	reply_t got;
	rec_t   incoming;

	// Apply one request to the list held here and return the reply it should produce.
	function automatic reply_t apply_request(input logic [2:0] op, input logic [POS_W-1:0] pos,
			input rec_t rec);
		reply_t rep;
		int     cnt;
		bit     hit;
		rep = '0;
		rep.status = STAT_OK;
		cnt = roster.size();
		hit = 1'b0;
		case (op)
			OP_INS_HEAD, OP_INS_TAIL, OP_INS_AT: begin
				if (cnt >= DEPTH)
					rep.status = STAT_FULL;
				else if (cnt == 0 || op == OP_INS_HEAD || (op == OP_INS_AT && pos <= 1))
					roster.push_front(rec);
				else if (op == OP_INS_TAIL || pos >= cnt)
					roster.push_back(rec);
				else
					roster.insert(pos - 1, rec);
			end
			OP_DEL_HEAD, OP_DEL_TAIL, OP_DEL_AT: begin
				if (cnt == 0)
					rep.status = STAT_EMPTY;
				else if (op == OP_DEL_HEAD || (op == OP_DEL_AT && pos == 1))
					roster.delete(0);
				else if (op == OP_DEL_TAIL)
					roster.delete(cnt - 1);
				else if (pos == 0 || pos > cnt)
					rep.status = STAT_BADPOS;
				else
					roster.delete(pos - 1);
			end
			OP_FIND: begin
				rep.status = STAT_NOTFOUND;
				// first match wins
				for (int i = 0; i < cnt; i++) begin
					if (!hit && roster[i].rest == rec.rest) begin
						hit = 1'b1;
						rep.status = STAT_OK;
						rep.fpos = POS_W'(i + 1);
						rep.fcountry = CODE_PORT_W'(roster[i].country);
						rep.fcity = CODE_PORT_W'(roster[i].city);
					end
				end
			end
			default: begin
			end
		endcase
		rep.count = POS_W'(roster.size());
		return rep;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			roster.delete();
			pending_replies.delete();
			mismatches = 0;
			outstanding = 0;
		end else begin
			// retire the result first so a transfer in the same cycle cannot match itself
			if (rsp_valid && rsp_ready) begin
				got = '{status, found_position, found_country, found_city, entry_count};
				if (pending_replies.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected result: st=%0d pos=%0d country=%h city=%h count=%0d",
							got.status, got.fpos, got.fcountry, got.fcity, got.count);
				end else begin
					want = pending_replies.pop_front();
					if (got !== want) begin
						mismatches++;
						if (mismatches <= 10) begin
							$display("mismatch: expected st=%0d pos=%0d country=%h city=%h count=%0d",
								want.status, want.fpos, want.fcountry, want.fcity, want.count);
							$display("          got      st=%0d pos=%0d country=%h city=%h count=%0d",
								got.status, got.fpos, got.fcountry, got.fcity, got.count);
						end
					end
				end
			end
			if (req_valid && req_ready) begin
				incoming.country = country_code[CODE_BITS-1:0];
				incoming.city = city_code[CODE_BITS-1:0];
				incoming.rest = restaurant_code[CODE_BITS-1:0];
				pending_replies.push_back(apply_request(opcode, position, incoming));
			end
			outstanding = pending_replies.size();
		end
	end

endmodule

// ===== tb/testbench.sv =====
// Top of the ordered record list testbench: clock, reset, stimulus, stalls and verdict.
`timescale 1ns / 1ps
module testbench;
	import orl_pkg::*;

	localparam logic [2:0] OP_SPARE = 3'd7;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int SEGMENTS       = 12;
	localparam int SEGMENT_ITEMS  = 150;
	localparam int HOLD_CYCLES    = 400;
	localparam int SETTLE_CYCLES  = 80;

	typedef enum int {
		MIX_FILL,
		MIX_BALANCED,
		MIX_DRAIN
	} traffic_t;

	logic                   clk;
	logic                   arst_n;
	logic                   req_valid;
	logic                   req_ready;
	logic [2:0]             opcode;
	logic [POS_W-1:0]       position;
	logic [CODE_PORT_W-1:0] country_code;
	logic [CODE_PORT_W-1:0] city_code;
	logic [CODE_PORT_W-1:0] restaurant_code;
	logic                   rsp_valid;
	logic                   rsp_ready;
	logic [2:0]             status;
	logic [POS_W-1:0]       found_position;
	logic [CODE_PORT_W-1:0] found_country;
	logic [CODE_PORT_W-1:0] found_city;
	logic [POS_W-1:0]       entry_count;

	int mismatches;
	int outstanding;
	int send_idle_pct;
	int recv_stall_pct;
	int squeeze_req;
	int squeeze_done;
	int quiet_cycles;

	ordered_record_list dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.req_valid       (req_valid),
		.req_ready       (req_ready),
		.opcode          (opcode),
		.position        (position),
		.country_code    (country_code),
		.city_code       (city_code),
		.restaurant_code (restaurant_code),
		.rsp_valid       (rsp_valid),
		.rsp_ready       (rsp_ready),
		.status          (status),
		.found_position  (found_position),
		.found_country   (found_country),
		.found_city      (found_city),
		.entry_count     (entry_count)
	);

	orl_checker u_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.req_valid       (req_valid),
		.req_ready       (req_ready),
		.opcode          (opcode),
		.position        (position),
		.country_code    (country_code),
		.city_code       (city_code),
		.restaurant_code (restaurant_code),
		.rsp_valid       (rsp_valid),
		.rsp_ready       (rsp_ready),
		.status          (status),
		.found_position  (found_position),
		.found_country   (found_country),
		.found_city      (found_city),
		.entry_count     (entry_count),
		.mismatches      (mismatches),
		.outstanding     (outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		arst_n = 1'b0;
		repeat (4) @(negedge clk);
		arst_n = 1'b1;
	end

	// Offer one request, idling first at the sender's rate, and hold it until the transfer.
	task automatic send_request(input logic [2:0] op, input logic [POS_W-1:0] pos,
			input logic [CODE_PORT_W-1:0] country, input logic [CODE_PORT_W-1:0] city,
			input logic [CODE_PORT_W-1:0] rest);
		@(negedge clk);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			req_valid <= 1'b0;
			@(negedge clk);
		end
		req_valid <= 1'b1;
		opcode <= op;
		position <= pos;
		country_code <= country;
		city_code <= city;
		restaurant_code <= rest;
		do @(posedge clk); while (!req_ready);
	endtask

	// Restaurant codes mostly come from a small pool so that finds hit and duplicates occur.
	function automatic logic [CODE_PORT_W-1:0] pick_restaurant();
		if ($urandom_range(0, 99) < 70)
			return CODE_PORT_W'($urandom_range(0, 23));
		return CODE_PORT_W'($urandom_range(0, 65535));
	endfunction

	task automatic random_request(input traffic_t mix);
		int               roll;
		int               ins_pct;
		int               find_pct;
		logic [2:0]       op;
		logic [POS_W-1:0] pos;
		roll = $urandom_range(0, 99);
		case (mix)
			MIX_FILL: begin
				ins_pct = 75;
				find_pct = 10;
			end
			MIX_DRAIN: begin
				ins_pct = 15;
				find_pct = 10;
			end
			default: begin
				ins_pct = 40;
				find_pct = 35;
			end
		endcase
		if (roll < ins_pct)
			op = 3'($urandom_range(OP_INS_HEAD, OP_INS_AT));
		else if (roll < ins_pct + find_pct)
			op = OP_FIND;
		else if (roll < 97)
			op = 3'($urandom_range(OP_DEL_HEAD, OP_DEL_AT));
		else
			op = OP_SPARE;
		if ($urandom_range(0, 99) < 80)
			pos = POS_W'($urandom_range(0, 70));
		else
			pos = POS_W'($urandom_range(0, 127));
		send_request(op, pos, CODE_PORT_W'($urandom_range(0, 65535)),
			CODE_PORT_W'($urandom_range(0, 65535)), pick_restaurant());
	endtask

	// Receiver: random stalls, or one long hold-off each time the stimulus asks for one.
	initial begin
		rsp_ready = 1'b0;
		squeeze_done = 0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			if (squeeze_done != squeeze_req) begin
				rsp_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				squeeze_done++;
			end else begin
				rsp_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
			end
		end
	end

	initial begin
		quiet_cycles = 0;
		forever begin
			@(posedge clk);
			if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("testbench: done, errors");
				$finish;
			end
		end
	end

	initial begin
		req_valid = 1'b0;
		opcode = OP_INS_HEAD;
		position = '0;
		country_code = '0;
		city_code = '0;
		restaurant_code = '0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		squeeze_req = 0;
		wait (arst_n === 1'b1);

		// empty list: spare opcode, every delete, find
		send_request(OP_SPARE, 7'd0, 16'h0000, 16'h0000, 16'h0000);
		send_request(OP_DEL_HEAD, 7'd0, 16'h0000, 16'h0000, 16'h0000);
		send_request(OP_DEL_TAIL, 7'd0, 16'h0000, 16'h0000, 16'h0000);
		send_request(OP_DEL_AT, 7'd1, 16'h0000, 16'h0000, 16'h0000);
		send_request(OP_FIND, 7'd0, 16'h0000, 16'h0000, 16'h0000);
		// insert into empty list with a far position, then each insert flavour
		send_request(OP_INS_AT, 7'd127, 16'hffff, 16'hffff, 16'hffff);
		send_request(OP_INS_HEAD, 7'd0, 16'h0000, 16'h0000, 16'h0000);
		send_request(OP_INS_TAIL, 7'd0, 16'h0001, 16'h0002, 16'h0003);
		send_request(OP_INS_AT, 7'd0, 16'haaaa, 16'h5555, 16'h0003);
		send_request(OP_INS_AT, 7'd1, 16'h5555, 16'haaaa, 16'h0010);
		send_request(OP_INS_AT, 7'd2, 16'h1234, 16'h5678, 16'h0020);
		send_request(OP_INS_AT, 7'd6, 16'h8000, 16'h0001, 16'h0030);
		// finds: the all-ones code, a duplicate code, a miss
		send_request(OP_FIND, 7'd0, 16'h0000, 16'h0000, 16'hffff);
		send_request(OP_FIND, 7'd0, 16'h0000, 16'h0000, 16'h0003);
		send_request(OP_FIND, 7'd127, 16'hffff, 16'hffff, 16'h1234);
		// bad positions, then deletes at head, middle, last and both ends
		send_request(OP_DEL_AT, 7'd0, 16'h0000, 16'h0000, 16'h0000);
		send_request(OP_DEL_AT, 7'd8, 16'h0000, 16'h0000, 16'h0000);
		send_request(OP_DEL_AT, 7'd127, 16'h0000, 16'h0000, 16'h0000);
		send_request(OP_DEL_AT, 7'd1, 16'h0000, 16'h0000, 16'h0000);
		send_request(OP_DEL_AT, 7'd3, 16'h0000, 16'h0000, 16'h0000);
		send_request(OP_DEL_AT, 7'd5, 16'h0000, 16'h0000, 16'h0000);
		send_request(OP_DEL_HEAD, 7'd0, 16'h0000, 16'h0000, 16'h0000);
		send_request(OP_DEL_TAIL, 7'd0, 16'h0000, 16'h0000, 16'h0000);
		send_request(OP_SPARE, 7'd127, 16'hffff, 16'hffff, 16'hffff);
		send_request(OP_FIND, 7'd0, 16'h0000, 16'h0000, 16'h0000);

		for (int seg = 0; seg < SEGMENTS; seg++) begin
			case (seg % 4)
				0: begin
					send_idle_pct = 0;
					recv_stall_pct = 0;
				end
				1: begin
					send_idle_pct = 73;
					recv_stall_pct = 0;
				end
				2: begin
					send_idle_pct = 0;
					recv_stall_pct = 73;
				end
				default: begin
					send_idle_pct = 19;
					recv_stall_pct = 19;
				end
			endcase
			// hold the receiver off while requests keep coming, to back the block up
			if (seg == 4 || seg == 8)
				squeeze_req++;
			for (int i = 0; i < SEGMENT_ITEMS; i++)
				random_request(traffic_t'(seg % 3));
		end

		@(negedge clk);
		req_valid <= 1'b0;
		while (outstanding != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
		if (mismatches == 0)
			$display("testbench: done, clean");
		else
			$display("testbench: done, errors");
		$finish;
	end

endmodule
